### design/jddm_pkg.sv
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types, constants and command codes for the joystick differential
// drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

    // Joystick band limits.
    localparam logic [13:0] FWD_END       = 14'd460;
    localparam logic [13:0] REV_START     = 14'd550;
    localparam logic [13:0] REV_END       = 14'd1500;
    localparam logic [13:0] REV_SPAN      = 14'd473;
    localparam logic [13:0] CONV_START_LO = 14'd2000;
    localparam logic [13:0] CONV_START_HI = 14'd3000;
    localparam logic [13:0] CONV_STOP_HI  = 14'd4000;

    // Duty scale and register reset.
    localparam logic [7:0]  FULL_DUTY       = 8'd255;
    localparam logic [7:0]  MIN_DRIVE_RESET = 8'd70;

    // H-bridge direction patterns.
    localparam logic [3:0]  PINS_IDLE    = 4'd0;
    localparam logic [3:0]  PINS_FORWARD = 4'd5;
    localparam logic [3:0]  PINS_REVERSE = 4'd10;

    // Conveyor command codes.
    localparam logic [1:0]  CMD_NONE  = 2'd0;
    localparam logic [1:0]  CMD_START = 2'd1;
    localparam logic [1:0]  CMD_STOP  = 2'd2;

    // Width of a scaled band offset and of the resulting magnitude.
    localparam int unsigned DIFF_W = 10;
    localparam int unsigned PROD_W = DIFF_W + 8;
    localparam int unsigned MAG_W  = 9;

    // Reciprocals for the two constant divisors. With the shift chosen as
    // numerator width plus divisor width, the rounded-up reciprocal gives an
    // exact truncated quotient for every numerator below 2**PROD_W.
    localparam int unsigned DIV_SHIFT = 27;
    localparam int unsigned RECIP_W   = 19;
    localparam longint unsigned DIV_ONE = 64'd1 << DIV_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_FWD =
        RECIP_W'((DIV_ONE + 64'(FWD_END) - 64'd1) / 64'(FWD_END));
    localparam logic [RECIP_W-1:0] RECIP_REV =
        RECIP_W'((DIV_ONE + 64'(REV_SPAN) - 64'd1) / 64'(REV_SPAN));

    // Which active band a reading falls in.
    typedef enum logic [1:0] {
        BAND_NONE,
        BAND_FWD,
        BAND_REV
    } band_t;

    // One joystick word.
    typedef struct packed {
        logic [13:0] x_axis;
        logic [13:0] y_axis;
    } joy_t;

    // One drive word.
    typedef struct packed {
        logic [7:0] speed_a;
        logic [7:0] speed_b;
        logic [3:0] bridge_pins;
        logic [1:0] conveyor_cmd;
    } drive_t;

endpackage

### design/jddm_scale.sv
// ----------------------------------------------------------------------------
// jddm_scale
// Classifies one joystick reading into its band and maps it to a duty
// magnitude with a reciprocal multiply.
// ----------------------------------------------------------------------------
module jddm_scale
    import jddm_pkg::*;
(
    input  logic [13:0]      value,
    output band_t            band,
    output logic [MAG_W-1:0] mag
);

    logic [DIFF_W-1:0]         diff;
    logic [RECIP_W-1:0]        recip;
    logic [PROD_W-1:0]         scaled;
    logic [PROD_W+RECIP_W-1:0] prod;

    // Band decode and offset from the band edge.
    always_comb
    begin
        band  = BAND_NONE;
        diff  = '0;
        recip = RECIP_FWD;
        if (value < FWD_END)
        begin
            band = BAND_FWD;
            diff = DIFF_W'(FWD_END - value);
        end
        else if (value > REV_START && value < REV_END)
        begin
            band  = BAND_REV;
            diff  = DIFF_W'(value - REV_START);
            recip = RECIP_REV;
        end
    end

    // Offset times full duty, then divide by the band span.
    assign scaled = {diff, 8'b0} - PROD_W'(diff);
    assign prod   = (PROD_W + RECIP_W)'(scaled) * (PROD_W + RECIP_W)'(recip);
    assign mag    = (band == BAND_NONE) ? '0 : prod[DIV_SHIFT +: MAG_W];

endmodule

### design/joystick_differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Arcade-drive mixer: joystick x/y words in, motor duties, H-bridge pins and
// conveyor commands out.
// ----------------------------------------------------------------------------
// The block takes one joystick word per cycle while the output side is not
// stalled and returns one drive word for each. The word passes through an
// input register, a register after the two reciprocal multipliers that scale
// the axes, and the output register; the input register is loaded at the
// accepting edge. Each stage advances when the stage after it can take the
// word, so a stall at the output holds the stages back. The bridge pins report
// the last direction pattern after the word, and min_drive is written through
// its own always-ready channel; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module joystick_differential_drive_mixer
    import jddm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       joy_valid,
    output logic       joy_ready,
    input  joy_t       joy,
    output logic       drive_valid,
    input  logic       drive_ready,
    output drive_t     drive,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_min_drive
);

    // Pipeline control.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_en, s2_en, s1_en;

    // Payload.
    joy_t                s1_data_reg;
    logic [MAG_W-1:0]    base_reg;
    logic signed [MAG_W:0] steer_reg;
    band_t               yband_reg;
    logic [1:0]          cmd_reg;
    drive_t              out_reg, out_next;

    // Control state.
    logic [3:0] bridge_reg, bridge_next;
    logic [7:0] min_drive_reg, min_drive_next;

    // Stage-two combinational results.
    band_t                 yband, xband;
    logic [MAG_W-1:0]      ymag, xmag;
    logic [1:0]            cmd;
    logic signed [MAG_W:0] steer;

    // Stage-three sums.
    logic signed [MAG_W+2:0] sum_a, sum_b;

    // Clamp to the duty range and apply the minimum drive.
    function automatic logic [7:0] finish(input logic signed [MAG_W+2:0] v,
                                          input logic [7:0] floor_val);
        logic [7:0] c;
        begin
            if (v < 0)
                c = '0;
            else if (v > $signed((MAG_W+3)'(FULL_DUTY)))
                c = FULL_DUTY;
            else
                c = v[7:0];
            finish = (c < floor_val) ? '0 : c;
        end
    endfunction

    // Handshakes: each stage moves when the one after it can take the word.
    assign out_en      = !out_valid_reg || drive_ready;
    assign s2_en       = !s2_valid_reg || out_en;
    assign s1_en       = !s1_valid_reg || s2_en;
    assign joy_ready   = s1_en;
    assign drive_valid = out_valid_reg;
    assign drive       = out_reg;
    assign cfg_ready   = 1'b1;

    // Axis scaling.
    jddm_scale u_scale_y
    (
        .value (s1_data_reg.y_axis),
        .band  (yband),
        .mag   (ymag)
    );

    jddm_scale u_scale_x
    (
        .value (s1_data_reg.x_axis),
        .band  (xband),
        .mag   (xmag)
    );

    // Conveyor decode and signed steering term for motor A.
    always_comb
    begin
        cmd = CMD_NONE;
        if (s1_data_reg.x_axis > CONV_START_LO && s1_data_reg.x_axis < CONV_START_HI)
            cmd = CMD_START;
        else if (s1_data_reg.x_axis > CONV_START_HI && s1_data_reg.x_axis < CONV_STOP_HI)
            cmd = CMD_STOP;

        steer = '0;
        if (cmd == CMD_NONE)
        begin
            unique case (xband)
                BAND_FWD: steer = $signed({1'b0, xmag});
                BAND_REV: steer = -$signed({1'b0, xmag});
                default:  steer = '0;
            endcase
        end
    end

    // Mix, saturate and track the bridge pattern.
    always_comb
    begin
        sum_a = $signed((MAG_W+3)'(base_reg)) + (MAG_W+3)'(steer_reg);
        sum_b = $signed((MAG_W+3)'(base_reg)) - (MAG_W+3)'(steer_reg);

        unique case (yband_reg)
            BAND_FWD: bridge_next = PINS_FORWARD;
            BAND_REV: bridge_next = PINS_REVERSE;
            default:  bridge_next = bridge_reg;
        endcase

        out_next.speed_a      = finish(sum_a, min_drive_reg);
        out_next.speed_b      = finish(sum_b, min_drive_reg);
        out_next.bridge_pins  = bridge_next;
        out_next.conveyor_cmd = cmd_reg;
    end

    // Next-state values of the control registers.
    always_comb
    begin
        s1_valid_next  = s1_en ? joy_valid : s1_valid_reg;
        s2_valid_next  = s2_en ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_en ? s2_valid_reg : out_valid_reg;
        min_drive_next = cfg_valid ? cfg_min_drive : min_drive_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bridge_reg    <= PINS_IDLE;
            min_drive_reg <= MIN_DRIVE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            min_drive_reg <= min_drive_next;
            if (out_en && s2_valid_reg)
                bridge_reg <= bridge_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_en)
            s1_data_reg <= joy;
        if (s2_en)
        begin
            base_reg  <= ymag;
            steer_reg <= steer;
            yband_reg <= yband;
            cmd_reg   <= cmd;
        end
        if (out_en)
            out_reg <= out_next;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the joystick differential drive mixer. Joystick
// words go in over a valid/ready channel with random gaps, drive words come
// back under random output stalls, and each drive word is checked field by
// field against a behavioral mixer kept in a small scoreboard. The min_drive
// register is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb
    import jddm_pkg::*;
;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PHASE_WORDS    = 188;
    localparam int unsigned CALM_WORDS     = 100;
    localparam int unsigned LATENCY        = 3;

    // Behavioral mixer plus the queue of drive words still to come back.
    class mixer_scoreboard;
        logic [7:0] min_drive;
        logic [3:0] bridge_state;
        drive_t     drive_words_due[$];
        int unsigned errors;
        int unsigned words_in;
        int unsigned words_checked;

        function new();
            min_drive     = MIN_DRIVE_RESET;
            bridge_state  = PINS_IDLE;
            errors        = 0;
            words_in      = 0;
            words_checked = 0;
        endfunction

        function band_t band_of(logic [13:0] v);
            if (v < FWD_END)
                return BAND_FWD;
            if (v > REV_START && v < REV_END)
                return BAND_REV;
            return BAND_NONE;
        endfunction

        // Scaled distance into a band; the reverse band may exceed full duty.
        function int band_magnitude(logic [13:0] v, band_t band);
            if (band == BAND_FWD)
                return ((int'(FWD_END) - int'(v)) * int'(FULL_DUTY)) / int'(FWD_END);
            if (band == BAND_REV)
                return ((int'(v) - int'(REV_START)) * int'(FULL_DUTY)) / int'(REV_SPAN);
            return 0;
        endfunction

        // Clamp to 0..255, then cut speeds below the minimum drive.
        function logic [7:0] final_speed(int v);
            if (v < 0)
                v = 0;
            if (v > int'(FULL_DUTY))
                v = int'(FULL_DUTY);
            if (v < int'(min_drive))
                return 8'd0;
            return v[7:0];
        endfunction

        function drive_t mix_drive(joy_t w);
            band_t      throttle_band;
            band_t      steer_band;
            int         motor_a;
            int         motor_b;
            int         steer;
            logic [1:0] cmd;
            drive_t     d;

            throttle_band = band_of(w.y_axis);
            if (throttle_band == BAND_FWD)
                bridge_state = PINS_FORWARD;
            else if (throttle_band == BAND_REV)
                bridge_state = PINS_REVERSE;
            motor_a = band_magnitude(w.y_axis, throttle_band);
            motor_b = motor_a;

            cmd = CMD_NONE;
            if (w.x_axis > CONV_START_LO && w.x_axis < CONV_START_HI)
                cmd = CMD_START;
            else if (w.x_axis > CONV_START_HI && w.x_axis < CONV_STOP_HI)
                cmd = CMD_STOP;

            // Steering only applies when x carries no conveyor code.
            if (cmd == CMD_NONE) begin
                steer_band = band_of(w.x_axis);
                steer = band_magnitude(w.x_axis, steer_band);
                if (steer_band == BAND_FWD) begin
                    motor_a += steer;
                    motor_b -= steer;
                end
                else if (steer_band == BAND_REV) begin
                    motor_a -= steer;
                    motor_b += steer;
                end
            end

            d.speed_a      = final_speed(motor_a);
            d.speed_b      = final_speed(motor_b);
            d.bridge_pins  = bridge_state;
            d.conveyor_cmd = cmd;
            return d;
        endfunction

        function void note_joystick(joy_t w);
            drive_words_due.push_back(mix_drive(w));
            words_in++;
        endfunction

        function void check_drive(drive_t got);
            drive_t want;

            if (drive_words_due.size() == 0) begin
                $display("%0t: unexpected drive word %h", $time, got);
                errors++;
                return;
            end
            want = drive_words_due.pop_front();
            words_checked++;
            if (got.speed_a !== want.speed_a) begin
                $display("%0t: speed_a expected %0d got %0d", $time, want.speed_a, got.speed_a);
                errors++;
            end
            if (got.speed_b !== want.speed_b) begin
                $display("%0t: speed_b expected %0d got %0d", $time, want.speed_b, got.speed_b);
                errors++;
            end
            if (got.bridge_pins !== want.bridge_pins) begin
                $display("%0t: bridge_pins expected %0d got %0d", $time,
                         want.bridge_pins, got.bridge_pins);
                errors++;
            end
            if (got.conveyor_cmd !== want.conveyor_cmd) begin
                $display("%0t: conveyor_cmd expected %0d got %0d", $time,
                         want.conveyor_cmd, got.conveyor_cmd);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return drive_words_due.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       joy_valid;
    logic       joy_ready;
    joy_t       joy;
    logic       drive_valid;
    logic       drive_ready;
    drive_t     drive;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_min_drive;

    mixer_scoreboard sb;
    bit              calm;
    int unsigned     quiet_cycles;
    int unsigned     settings_used;

    joystick_differential_drive_mixer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .joy_valid    (joy_valid),
        .joy_ready    (joy_ready),
        .joy          (joy),
        .drive_valid  (drive_valid),
        .drive_ready  (drive_ready),
        .drive        (drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_min_drive(cfg_min_drive)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Sample every handshake at the rising edge and feed the scoreboard.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.min_drive = cfg_min_drive;
            if (joy_valid && joy_ready)
                sb.note_joystick(joy);
            if (drive_valid && drive_ready)
                sb.check_drive(drive);
            if ((cfg_valid && cfg_ready) || (joy_valid && joy_ready)
                || (drive_valid && drive_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: too long without any word moving means the block is stuck.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: timeout, %0d drive words outstanding", $time, sb.pending());
        $display("tb NOT OK");
        $finish;
    end

    // Output side: ready with random stall bursts, none once the run calms.
    initial begin
        int unsigned stall_left;

        drive_ready = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                drive_ready <= 1'b0;
                stall_left--;
            end
            else begin
                drive_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    // Present one joystick word and hold it until accepted.
    task automatic send_joystick(input logic [13:0] x, input logic [13:0] y);
        joy_t w;

        w.x_axis = x;
        w.y_axis = y;
        joy       <= w;
        joy_valid <= 1'b1;
        do
            @(posedge clk);
        while (!joy_ready);
        @(negedge clk);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        joy_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Stop sending until every expected drive word has come back.
    task automatic drain();
        joy_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY + 1) @(negedge clk);
    endtask

    task automatic write_min_drive(input logic [7:0] value);
        drain();
        cfg_min_drive <= value;
        cfg_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Axis value biased toward the bands, their edges and the conveyor codes.
    function automatic logic [13:0] pick_axis(bit conveyor_codes);
        logic [13:0] edges[16] = '{14'd0, 14'd459, 14'd460, 14'd550, 14'd551, 14'd1499,
                                   14'd1500, 14'd2000, 14'd2001, 14'd2999, 14'd3000,
                                   14'd3001, 14'd3999, 14'd4000, 14'd9999, 14'd16383};

        case ($urandom_range(0, 11))
            0, 1, 2: return 14'($urandom_range(0, 459));
            3, 4, 5: return 14'($urandom_range(551, 1499));
            6:       return edges[$urandom_range(0, 15)];
            7:       return 14'($urandom_range(460, 550));
            8, 9:    return conveyor_codes ? 14'($urandom_range(2001, 3999))
                                           : 14'($urandom_range(1500, 9999));
            10:      return 14'($urandom_range(1500, 9999));
            default: return 14'($urandom_range(0, 16383));
        endcase
    endfunction

    initial begin
        logic [7:0] phase_setting[4];
        int unsigned phase;
        int unsigned n;

        rst_n         = 1'b0;
        joy_valid     = 1'b0;
        joy           = '0;
        cfg_valid     = 1'b0;
        cfg_min_drive = '0;
        calm          = 1'b0;
        settings_used = 1;
        sb            = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words under the reset minimum drive. The first one is in
        // the dead zone, so the bridge pins still show their reset pattern.
        send_joystick(14'd500, 14'd500);
        send_joystick(14'd500, 14'd0);
        send_joystick(14'd500, 14'd459);
        send_joystick(14'd500, 14'd460);
        send_joystick(14'd500, 14'd550);
        send_joystick(14'd500, 14'd551);
        send_joystick(14'd500, 14'd1499);
        send_joystick(14'd500, 14'd1500);
        send_joystick(14'd500, 14'd9999);
        send_joystick(14'd500, 14'd16383);
        // Full steering against full throttle saturates both ways.
        send_joystick(14'd0, 14'd0);
        send_joystick(14'd1499, 14'd0);
        send_joystick(14'd0, 14'd1499);
        send_joystick(14'd1499, 14'd1499);
        send_joystick(14'd459, 14'd230);
        send_joystick(14'd460, 14'd230);
        send_joystick(14'd551, 14'd230);
        send_joystick(14'd300, 14'd230);
        // Conveyor codes and the values just outside them.
        send_joystick(14'd2000, 14'd0);
        send_joystick(14'd2001, 14'd0);
        send_joystick(14'd2999, 14'd900);
        send_joystick(14'd3000, 14'd900);
        send_joystick(14'd3001, 14'd900);
        send_joystick(14'd3999, 14'd200);
        send_joystick(14'd4000, 14'd200);
        send_joystick(14'd16383, 14'd16383);

        // Random phases, each under its own minimum drive setting.
        phase_setting[0] = 8'd0;
        phase_setting[1] = 8'd255;
        phase_setting[2] = 8'($urandom_range(1, 254));
        phase_setting[3] = MIN_DRIVE_RESET;
        for (phase = 0; phase < 4; phase++) begin
            write_min_drive(phase_setting[phase]);
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 3 && n == PHASE_WORDS - CALM_WORDS)
                    calm = 1'b1;
                send_joystick(pick_axis(1'b1), pick_axis(1'b0));
                if (!calm && $urandom_range(0, 149) == 0)
                    drain();
                else if (!calm && $urandom_range(0, 3) == 0)
                    sender_gap($urandom_range(1, 7));
            end
        end

        drain();
        $display("Sent %0d joystick words and checked %0d drive words under %0d min_drive",
                 sb.words_in, sb.words_checked, settings_used);
        $display("settings, covering band edges, conveyor codes, clamping and dead zones.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
